// ----- rtl/sorted_table_binary_search_unit_macros.svh -----
// Assertion macros for the sorted table binary search unit.
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sbs_pkg.sv -----
// Shared constants, types and command/status structs for the binary search unit.
package sbs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } sbs_state_t;

  typedef struct packed {
    logic start;     // latch key and range, read first midpoint
    logic write;     // store one table word
    logic step;      // compare probe, narrow range, read next midpoint
    logic load_out;  // move pending result to the output register
  } sbs_cmd_t;

  typedef struct packed {
    logic count_zero;  // search range empty from the start
    logic hit;         // current probe equals the key
    logic miss;        // range empties after this probe
  } sbs_sts_t;

endpackage

// ----- rtl/sbs_channels.sv -----
// Channel interfaces: search/write items, results and the count register write.
interface sbs_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [sbs_pkg::ADDR_W-1:0]           entry_index;
  logic signed [sbs_pkg::DATA_W-1:0]    entry_value;
  logic signed [sbs_pkg::DATA_W-1:0]    search_key;

  modport source (output valid, func, entry_index, entry_value, search_key, input ready);
  modport sink   (input valid, func, entry_index, entry_value, search_key, output ready);
endinterface

interface sbs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [sbs_pkg::ADDR_W-1:0] match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

interface sbs_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [sbs_pkg::CNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

// ----- rtl/sbs_ctrl.sv -----
// Controller state machine: sequences writes, search probes and result hand-off.
module sbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sbs_pkg::sbs_cmd_t cmd,
  input  sbs_pkg::sbs_sts_t sts
);
  import sbs_pkg::*;

  sbs_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == FUNC_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = sts.count_zero ? ST_EMIT : ST_SEARCH;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.hit || sts.miss) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold the result until the output slot frees up
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/sbs_dp.sv -----
// Datapath: table memory, count register, search range, probe compare and result registers.
module sbs_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  sbs_pkg::sbs_cmd_t                cmd,
  output sbs_pkg::sbs_sts_t                sts,
  input  logic                             cfg_we,
  input  logic [sbs_pkg::CNT_W-1:0]        cfg_count,
  input  logic [sbs_pkg::ADDR_W-1:0]       entry_index,
  input  logic signed [sbs_pkg::DATA_W-1:0] entry_value,
  input  logic signed [sbs_pkg::DATA_W-1:0] search_key,
  output logic                             out_found,
  output logic [sbs_pkg::ADDR_W-1:0]       out_index
);
  import sbs_pkg::*;

  logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_data;

  logic [CNT_W-1:0]         entry_count;
  logic [CNT_W-1:0]         count_sat;
  logic [CNT_W-1:0]         count_m1;
  logic signed [DATA_W-1:0] key;
  logic [CNT_W-1:0]         lo, lo_next;
  logic [CNT_W-1:0]         hi_end, hi_end_next;
  logic [ADDR_W-1:0]        mid, mid_first, mid_next, rd_addr;
  logic [CNT_W:0]           mid_sum;
  logic                     res_found;
  logic [ADDR_W-1:0]        res_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_count;
    end
  end

  // saturate the count at the table depth
  assign count_sat = (entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entry_count;
  assign count_m1  = count_sat - CNT_W'(1);
  assign mid_first = count_m1[ADDR_W:1];

  assign sts.count_zero = (count_sat == '0);
  assign sts.hit        = (rd_data == key);

  // range is [lo, hi_end); a smaller probe moves lo up, a larger one pulls hi_end down
  always_comb begin
    if (rd_data < key) begin
      lo_next     = {1'b0, mid} + CNT_W'(1);
      hi_end_next = hi_end;
    end else begin
      lo_next     = lo;
      hi_end_next = {1'b0, mid};
    end
    mid_sum  = {1'b0, lo_next} + {1'b0, hi_end_next} - (CNT_W + 1)'(1);
    mid_next = mid_sum[ADDR_W:1];
  end

  assign sts.miss = !sts.hit && (lo_next >= hi_end_next);
  assign rd_addr  = cmd.start ? mid_first : mid_next;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      table_mem[entry_index] <= entry_value;
    end else if (cmd.start || cmd.step) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key       <= search_key;
      lo        <= '0;
      hi_end    <= count_sat;
      mid       <= mid_first;
      res_found <= 1'b0;
      res_index <= '0;
    end else if (cmd.step) begin
      lo        <= lo_next;
      hi_end    <= hi_end_next;
      mid       <= mid_next;
      res_found <= sts.hit;
      res_index <= sts.hit ? mid : '0;
    end
    if (cmd.load_out) begin
      out_found <= res_found;
      out_index <= res_index;
    end
  end

endmodule

// ----- rtl/sorted_table_binary_search_unit.sv -----
// Binary search over a sorted table of up to 256 signed words held in a single-port memory.
// A write item stores its word. A search item reads and compares one probe per cycle (1 to 9
// probes for 256 entries, none when the count is zero), then moves its result into the output
// register; the input is taken again only after that load, so a search holds the input until
// its result is loaded. The output register frees the input: a new item is taken while a result
// still waits, and a finished search stalls only while that register is still full. The count
// register (saturated at 256) may be written at any time the block is idle; the table is not
// cleared by reset.
`include "sorted_table_binary_search_unit_macros.svh"

module sorted_table_binary_search_unit (
  input  logic       clk,
  input  logic       rst,
  sbs_req_if.sink    req,
  sbs_rsp_if.source  rsp,
  sbs_cfg_if.sink    cfg
);
  import sbs_pkg::*;

  sbs_cmd_t cmd;
  sbs_sts_t sts;

  assign cfg.ready = 1'b1;

  sbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .func      (req.func),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sbs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_count   (cfg.entry_count),
    .entry_index (req.entry_index),
    .entry_value (req.entry_value),
    .search_key  (req.search_key),
    .out_found   (rsp.found),
    .out_index   (rsp.match_index)
  );

  `SBS_ASSERT_NEXT(a_load_shows_result, cmd.load_out, rsp.valid, "result load did not raise valid")
  `SBS_ASSERT_NOW(a_no_accept_mid_search, cmd.step, !req.ready, "input ready during a search")
  `SBS_ASSERT_NEXT(a_hit_ends_search, cmd.step && sts.hit, !cmd.step, "search kept probing after a hit")

endmodule
